// File: hw/rtl/fcdc_pkg.sv
`default_nettype none

package fcdc_pkg;

    // storage sizes
    localparam int BUFFER_DEPTH_DEF = 9;
    localparam int DUTY_DIGITS      = 3;
    localparam int DIGIT_BASE       = 4;

    // characters
    localparam logic [7:0] END_MARK   = 8'h2A;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;

    // keywords, first character in the top byte, padded with zeros
    localparam int KW_BITS = 48;
    localparam logic [KW_BITS-1:0] KW_VEL    = {"VEL", 24'h0};
    localparam logic [KW_BITS-1:0] KW_VENT   = {"VENT", 16'h0};
    localparam logic [KW_BITS-1:0] KW_EXAUST = {"EXAUST"};
    localparam logic [KW_BITS-1:0] KW_PARA   = {"PARA", 16'h0};
    localparam logic [KW_BITS-1:0] KW_RETVEL = {"RETVEL"};

    // duty and pwm scaling: pwm = duty * 255 / 100 = (duty * 1336965) >> 19
    localparam logic [6:0]  DUTY_MAX   = 7'd100;
    localparam logic [20:0] PWM_RECIP  = 21'd1336965;
    localparam int          PWM_SHIFT  = 19;

    // configuration reset values
    localparam logic [15:0] WINDOW_RESET = 16'd1000;
    localparam logic [7:0]  RPP_RESET    = 8'd15;

    // register map, selected by address bit 2
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_RPP    = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_TACH = 2'd1,
        KIND_TICK = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        RESP_NONE    = 3'd0,
        RESP_DUTY    = 3'd1,
        RESP_VENT    = 3'd2,
        RESP_EXHAUST = 3'd3,
        RESP_STOP    = 3'd4,
        RESP_SPEED   = 3'd5,
        RESP_UNKNOWN = 3'd6
    } t_resp;

    typedef enum logic [1:0] {
        DIR_IDLE    = 2'd0,
        DIR_VENT    = 2'd1,
        DIR_EXHAUST = 2'd2
    } t_dir;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] window_ticks;
        logic [7:0]  rpm_per_pulse;
    } t_cfg;

    typedef struct packed {
        t_resp      response;
        logic [6:0] duty;
        logic [7:0] pwm;
        t_dir       req_dir;
    } t_cmd_res;

    typedef struct packed {
        logic [15:0] speed;
        logic        stop_seen;
    } t_speed_res;

    typedef struct packed {
        logic fwd;
        logic rev;
        t_dir dir;
        logic stopped;
    } t_bridge_res;

endpackage

`default_nettype wire

// File: hw/rtl/fcdc_cmd.sv
`default_nettype none

module fcdc_cmd
    import fcdc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_item    i_item,
    output t_cmd_res      o_res
);

    localparam int FW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]        r_chars [BUFFER_DEPTH];
    logic [3:0]        r_digits [DUTY_DIGITS];
    logic [FW-1:0]     r_fill;
    logic [6:0]        r_duty;
    logic [7:0]        r_pwm;
    t_dir              r_req;

    logic [FW-1:0]     n_fill;
    logic [6:0]        n_duty;
    logic [7:0]        n_pwm;
    t_dir              n_req;
    t_resp             n_resp;

    logic [KW_BITS-1:0] head;
    logic               is_byte;
    logic               is_end;
    logic               store;
    logic [3:0]         digit;
    logic [9:0]         raw_duty;
    logic [6:0]         sat_duty;
    logic [27:0]        pwm_prod;

    // keyword match: enough characters buffered and each leading one equal
    function automatic logic kw_hit(input logic [KW_BITS-1:0] kw, input logic [2:0] len,
                                    input logic [KW_BITS-1:0] buf_head,
                                    input logic [FW-1:0] fill);
        logic hit;
        hit = (fill >= FW'(len));
        for (int j = 0; j < KW_BITS / 8; j++) begin
            if (3'(j) < len && buf_head[KW_BITS-1-8*j -: 8] != kw[KW_BITS-1-8*j -: 8]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    always_comb begin
        for (int j = 0; j < KW_BITS / 8; j++) begin
            head[KW_BITS-1-8*j -: 8] = r_chars[j];
        end
    end

    assign is_byte = (i_item.kind == KIND_BYTE);
    assign is_end  = (i_item.rx_byte == END_MARK);
    assign store   = is_byte && !is_end && (r_fill < FW'(BUFFER_DEPTH));
    assign digit   = (i_item.rx_byte >= ASCII_ZERO && i_item.rx_byte <= ASCII_NINE)
                   ? 4'(i_item.rx_byte - ASCII_ZERO) : 4'd0;

    // duty from the stored digits, saturated, then scaled to the pwm range
    assign raw_duty = 10'(r_digits[0]) * 10'd100 + 10'(r_digits[1]) * 10'd10
                    + 10'(r_digits[2]);
    assign sat_duty = (raw_duty > 10'(DUTY_MAX)) ? DUTY_MAX : raw_duty[6:0];
    assign pwm_prod = 28'(sat_duty) * 28'(PWM_RECIP);

    always_comb begin
        n_fill = r_fill;
        n_duty = r_duty;
        n_pwm  = r_pwm;
        n_req  = r_req;
        n_resp = RESP_NONE;
        if (i_step && is_byte) begin
            if (is_end) begin
                if (r_fill != '0) begin
                    n_fill = '0;
                    if (kw_hit(KW_VEL, 3'd3, head, r_fill)) begin
                        n_resp = RESP_DUTY;
                        n_duty = sat_duty;
                        n_pwm  = pwm_prod[PWM_SHIFT +: 8];
                    end else if (kw_hit(KW_VENT, 3'd4, head, r_fill)) begin
                        n_resp = RESP_VENT;
                        n_req  = DIR_VENT;
                    end else if (kw_hit(KW_EXAUST, 3'd6, head, r_fill)) begin
                        n_resp = RESP_EXHAUST;
                        n_req  = DIR_EXHAUST;
                    end else if (kw_hit(KW_PARA, 3'd4, head, r_fill)) begin
                        n_resp = RESP_STOP;
                        n_req  = DIR_IDLE;
                    end else if (kw_hit(KW_RETVEL, 3'd6, head, r_fill)) begin
                        n_resp = RESP_SPEED;
                    end else begin
                        n_resp = RESP_UNKNOWN;
                    end
                end
            end else if (store) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // character store, no reset; the digit store below clears to zero on reset
    always_ff @(posedge i_clk) begin
        if (i_step && store) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                if (r_fill == FW'(i)) begin
                    r_chars[i] <= i_item.rx_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DUTY_DIGITS; i++) begin
                r_digits[i] <= 4'd0;
            end
        end else if (i_step && store) begin
            for (int i = 0; i < DUTY_DIGITS; i++) begin
                if (r_fill == FW'(DIGIT_BASE + i)) begin
                    r_digits[i] <= digit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_duty <= '0;
            r_pwm  <= '0;
            r_req  <= DIR_IDLE;
        end else begin
            r_fill <= n_fill;
            r_duty <= n_duty;
            r_pwm  <= n_pwm;
            r_req  <= n_req;
        end
    end

    assign o_res.response = n_resp;
    assign o_res.duty     = n_duty;
    assign o_res.pwm      = n_pwm;
    assign o_res.req_dir  = n_req;

endmodule

`default_nettype wire

// File: hw/rtl/fcdc_speed.sv
`default_nettype none

module fcdc_speed
    import fcdc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_kind    i_kind,
    input  wire t_cfg     i_cfg,
    output t_speed_res    o_res
);

    logic [15:0] r_pulse;
    logic [15:0] r_tick;
    logic [15:0] r_speed;

    logic [15:0] n_pulse;
    logic [15:0] n_tick;
    logic [15:0] n_speed;
    logic        stop_seen;

    logic [16:0] tick_inc;
    logic [23:0] prod;
    logic [15:0] sat_speed;

    assign tick_inc  = 17'(r_tick) + 17'd1;
    assign prod      = 24'(r_pulse) * 24'(i_cfg.rpm_per_pulse);
    assign sat_speed = (prod[23:16] != '0) ? 16'hFFFF : prod[15:0];

    always_comb begin
        n_pulse   = r_pulse;
        n_tick    = r_tick;
        n_speed   = r_speed;
        stop_seen = 1'b0;
        if (i_step) begin
            case (i_kind)
                KIND_TACH: begin
                    if (r_pulse != 16'hFFFF) begin
                        n_pulse = r_pulse + 16'd1;
                    end
                end
                KIND_TICK: begin
                    // window closes once the count passes the programmed length
                    if (tick_inc > 17'(i_cfg.window_ticks)) begin
                        n_speed   = sat_speed;
                        n_pulse   = '0;
                        n_tick    = '0;
                        stop_seen = (sat_speed == '0);
                    end else begin
                        n_tick = tick_inc[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse <= '0;
            r_tick  <= '0;
            r_speed <= '0;
        end else begin
            r_pulse <= n_pulse;
            r_tick  <= n_tick;
            r_speed <= n_speed;
        end
    end

    assign o_res.speed     = n_speed;
    assign o_res.stop_seen = stop_seen;

endmodule

`default_nettype wire

// File: hw/rtl/fcdc_bridge.sv
`default_nettype none

module fcdc_bridge
    import fcdc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_dir     i_req,
    input  wire logic     i_stop_seen,
    output t_bridge_res   o_res
);

    t_dir r_dir;
    logic r_stopped;

    t_dir n_dir;
    logic n_stopped;
    logic stop_eff;
    logic fwd;
    logic rev;

    assign stop_eff = r_stopped || i_stop_seen;

    // interlock: a reversal has to pass through idle, and idle needs a stopped motor
    always_comb begin
        fwd       = 1'b0;
        rev       = 1'b0;
        n_dir     = r_dir;
        n_stopped = stop_eff;
        case (i_req)
            DIR_VENT, DIR_EXHAUST: begin
                if (r_dir == DIR_IDLE || r_dir == i_req) begin
                    fwd       = (i_req == DIR_VENT);
                    rev       = (i_req == DIR_EXHAUST);
                    n_dir     = i_req;
                    n_stopped = 1'b0;
                end else if (stop_eff) begin
                    n_dir = DIR_IDLE;
                end
            end
            default: begin
                if (stop_eff) begin
                    n_dir = DIR_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir     <= DIR_IDLE;
            r_stopped <= 1'b1;
        end else if (i_step) begin
            r_dir     <= n_dir;
            r_stopped <= n_stopped;
        end
    end

    assign o_res.fwd     = fwd;
    assign o_res.rev     = rev;
    assign o_res.dir     = n_dir;
    assign o_res.stopped = n_stopped;

endmodule

`default_nettype wire

// File: hw/rtl/fan_command_direction_controller_core.sv
// channel   | handshake                  | payload
// ----------+----------------------------+----------------------------------------------
// input     | i_in_valid / o_in_stall    | i_kind, i_rx_byte
// output    | o_out_valid / i_out_stall  | o_response, o_speed_rpm, o_duty_percent,
//           |                            | o_pwm_level, o_bridge_forward, o_bridge_reverse,
//           |                            | o_direction, o_stopped
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// one transaction per clock in steady state while the output is not stalled; a transaction
// passes the input register, then one pass through command, speed and interlock logic into
// the result register, from which the result is offered until it is taken
// synchronous active-low reset clears all control state; configuration comes back at
// window_ticks 1000 and rpm_per_pulse 15
// a stall at the output holds the result register and backs up into the input register;
// o_in_stall rises only once both are full
`default_nettype none

module fan_command_direction_controller_core
    import fcdc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input transaction
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_rx_byte,

    // result transaction
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_response,
    output logic [15:0]      o_speed_rpm,
    output logic [6:0]       o_duty_percent,
    output logic [7:0]       o_pwm_level,
    output logic             o_bridge_forward,
    output logic             o_bridge_reverse,
    output logic [1:0]       o_direction,
    output logic             o_stopped,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    t_cfg        r_cfg;
    logic        cfg_wr;

    // input register
    logic        r_in_valid;
    t_item       r_item;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_response;
    logic [15:0] r_speed;
    logic [6:0]  r_duty;
    logic [7:0]  r_pwm;
    logic        r_fwd;
    logic        r_rev;
    logic [1:0]  r_dir;
    logic        r_stopped;

    logic        advance;
    logic        step;

    t_cmd_res    cmd_res;
    t_speed_res  speed_res;
    t_bridge_res bridge_res;

    // apb: zero-wait, writes land on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks  <= WINDOW_RESET;
            r_cfg.rpm_per_pulse <= RPP_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WINDOW: r_cfg.window_ticks  <= pwdata[15:0];
                REG_RPP:    r_cfg.rpm_per_pulse <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WINDOW: prdata = 32'(r_cfg.window_ticks);
            REG_RPP:    prdata = 32'(r_cfg.rpm_per_pulse);
            default:    prdata = '0;
        endcase
    end

    // result register frees up when empty or when its transaction is taken this cycle
    assign advance    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_item.kind    <= t_kind'(i_kind);
            r_item.rx_byte <= i_rx_byte;
        end
    end

    // command buffer, keyword decode, duty and pwm
    fcdc_cmd #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_cmd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_item),
        .o_res   (cmd_res)
    );

    // tach pulse count and speed window
    fcdc_speed u_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_kind  (r_item.kind),
        .i_cfg   (r_cfg),
        .o_res   (speed_res)
    );

    // h-bridge interlock sees this transaction's request and stop detection
    fcdc_bridge u_bridge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_req       (cmd_res.req_dir),
        .i_stop_seen (speed_res.stop_seen),
        .o_res       (bridge_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_response <= cmd_res.response;
            r_speed    <= speed_res.speed;
            r_duty     <= cmd_res.duty;
            r_pwm      <= cmd_res.pwm;
            r_fwd      <= bridge_res.fwd;
            r_rev      <= bridge_res.rev;
            r_dir      <= bridge_res.dir;
            r_stopped  <= bridge_res.stopped;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_response       = r_response;
    assign o_speed_rpm      = r_speed;
    assign o_duty_percent   = r_duty;
    assign o_pwm_level      = r_pwm;
    assign o_bridge_forward = r_fwd;
    assign o_bridge_reverse = r_rev;
    assign o_direction      = r_dir;
    assign o_stopped        = r_stopped;

endmodule

`default_nettype wire
